// ===== rtl/core/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types and constants for the Euler angle to quaternion unit.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int ANGLE_W = 16;
    localparam int QUAT_W = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;

    // Half-angle sine and cosine travel as signed Q2.30.
    localparam int TRIG_W = 32;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] yaw_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] roll_angle;
    } t_angles;

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
    } t_quat;

    typedef struct packed {
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
    } t_sc;

endpackage

// ===== rtl/core/e2q_trig.sv =====
// ----------------------------------------------------------------------------
// e2q_trig
// Three-stage sine and cosine of a half angle given in 1/128 degree units.
// ----------------------------------------------------------------------------
module e2q_trig (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] i_angle,
    output e2q_pkg::t_sc                     o_sc
);
    import e2q_pkg::*;

    localparam int TURN = 46080;
    localparam int QUAD = 11520;
    localparam int OCT  = 5760;

    // Stage 1: reduce to [0, TURN), split into quadrant and residue, and fold
    // the residue into the first octant.
    logic [15:0] a;
    logic [1:0]  n_quad;
    logic [13:0] n_res;
    logic        n_swap;
    logic [12:0] n_t;
    logic [1:0]  r_quad;
    logic        r_swap;
    logic [12:0] r_t;

    always_comb begin
        if (i_angle < 0) begin
            a = 16'(32'(signed'(i_angle)) + TURN);
        end else begin
            a = 16'(i_angle);
        end
        if (a >= 16'(3*QUAD)) begin
            n_quad = 2'd3; n_res = 14'(a - 16'(3*QUAD));
        end else if (a >= 16'(2*QUAD)) begin
            n_quad = 2'd2; n_res = 14'(a - 16'(2*QUAD));
        end else if (a >= 16'(QUAD)) begin
            n_quad = 2'd1; n_res = 14'(a - 16'(QUAD));
        end else begin
            n_quad = 2'd0; n_res = 14'(a);
        end
        n_swap = (n_res > 14'(OCT));
        if (n_swap) begin
            n_t = 13'(14'(QUAD) - n_res);
        end else begin
            n_t = 13'(n_res);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quad <= n_quad;
            r_swap <= n_swap;
            r_t    <= n_t;
        end
    end

    // Stage 2: the octant angle is split into a coarse part of 32 units and
    // a fine part; each part has its own constant sine and cosine tables,
    // built at elaboration from Taylor series.
    localparam int  TAB_W   = 31;
    localparam int  LO_BITS = 5;
    localparam int  HI_N    = 181;
    localparam int  LO_N    = 32;
    localparam real PI_R    = 3.14159265358979;
    localparam real RAD_PER_UNIT = PI_R / 23040.0;
    localparam real Q30_R   = 1073741824.0;
    localparam real R2   = 1.0 / 2.0;
    localparam real R6   = 1.0 / 6.0;
    localparam real R12  = 1.0 / 12.0;
    localparam real R20  = 1.0 / 20.0;
    localparam real R30  = 1.0 / 30.0;
    localparam real R42  = 1.0 / 42.0;
    localparam real R56  = 1.0 / 56.0;
    localparam real R72  = 1.0 / 72.0;
    localparam real R90  = 1.0 / 90.0;
    localparam real R110 = 1.0 / 110.0;
    localparam real R132 = 1.0 / 132.0;
    localparam real R156 = 1.0 / 156.0;

    function automatic logic [TAB_W-1:0] sin_q30(input int units);
        real x;
        real x2;
        real r;
        x  = RAD_PER_UNIT * real'(units);
        x2 = x * x;
        r  = x * (1.0 - x2 * R6 * (1.0 - x2 * R20 * (1.0 - x2 * R42 *
             (1.0 - x2 * R72 * (1.0 - x2 * R110 * (1.0 - x2 * R156))))));
        return TAB_W'($rtoi(r * Q30_R + 0.5));
    endfunction

    function automatic logic [TAB_W-1:0] cos_q30(input int units);
        real x;
        real x2;
        real r;
        x  = RAD_PER_UNIT * real'(units);
        x2 = x * x;
        r  = 1.0 - x2 * R2 * (1.0 - x2 * R12 * (1.0 - x2 * R30 *
             (1.0 - x2 * R56 * (1.0 - x2 * R90 * (1.0 - x2 * R132)))));
        return TAB_W'($rtoi(r * Q30_R + 0.5));
    endfunction

    logic [TAB_W-1:0] hi_sin [HI_N];
    logic [TAB_W-1:0] hi_cos [HI_N];
    logic [TAB_W-1:0] lo_sin [LO_N];
    logic [TAB_W-1:0] lo_cos [LO_N];

    for (genvar g = 0; g < HI_N; g++) begin : g_hi
        assign hi_sin[g] = sin_q30(g << LO_BITS);
        assign hi_cos[g] = cos_q30(g << LO_BITS);
    end

    for (genvar g = 0; g < LO_N; g++) begin : g_lo
        assign lo_sin[g] = sin_q30(g);
        assign lo_cos[g] = cos_q30(g);
    end

    logic [TAB_W-1:0] r_sa;
    logic [TAB_W-1:0] r_ca;
    logic [TAB_W-1:0] r_sb;
    logic [TAB_W-1:0] r_cb;
    logic [1:0]       r_quad2;
    logic             r_swap2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sa    <= hi_sin[r_t[12:LO_BITS]];
            r_ca    <= hi_cos[r_t[12:LO_BITS]];
            r_sb    <= lo_sin[r_t[LO_BITS-1:0]];
            r_cb    <= lo_cos[r_t[LO_BITS-1:0]];
            r_quad2 <= r_quad;
            r_swap2 <= r_swap;
        end
    end

    // Stage 3: angle addition, rounding to Q2.30, then octant and quadrant
    // folding. Within the first octant the cosine term never goes negative.
    localparam int PW       = 2 * TAB_W + 1;
    localparam int RND_Q30  = 1 << 29;

    logic [PW-1:0]            sum_s;
    logic [PW-1:0]            sum_c;
    logic [TAB_W-1:0]         s_oct;
    logic [TAB_W-1:0]         c_oct;
    logic signed [TRIG_W-1:0] s_fold;
    logic signed [TRIG_W-1:0] c_fold;
    t_sc                      n_sc;

    always_comb begin
        sum_s = PW'(r_sa) * PW'(r_cb) + PW'(r_ca) * PW'(r_sb);
        sum_c = PW'(r_ca) * PW'(r_cb) - PW'(r_sa) * PW'(r_sb);
        s_oct = TAB_W'((sum_s + PW'(RND_Q30)) >> 30);
        c_oct = TAB_W'((sum_c + PW'(RND_Q30)) >> 30);
        if (r_swap2) begin
            s_fold = signed'(TRIG_W'(c_oct));
            c_fold = signed'(TRIG_W'(s_oct));
        end else begin
            s_fold = signed'(TRIG_W'(s_oct));
            c_fold = signed'(TRIG_W'(c_oct));
        end
        case (r_quad2)
            2'd0: begin n_sc.s = s_fold;  n_sc.c = c_fold;  end
            2'd1: begin n_sc.s = c_fold;  n_sc.c = -s_fold; end
            2'd2: begin n_sc.s = -s_fold; n_sc.c = -c_fold; end
            default: begin n_sc.s = -c_fold; n_sc.c = s_fold; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sc <= n_sc;
        end
    end
endmodule

// ===== rtl/core/euler_to_quaternion_unit.sv =====
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit
// Pipelined conversion of yaw, pitch and roll to a unit quaternion.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one transaction of three angles in
// 1/64 degree units; the output channel carries one transaction of w, x, y,
// z in Q2.14 (OUT_FRAC_BITS fraction bits). Each half angle is folded into
// the first octant, its sine and cosine are built from a coarse and a fine
// table by angle addition, pairwise products are formed in one stage and
// the triple products and sums in the next, then rounded.
// The pipeline has three trig stages, then one stage each for the pair
// products, the triple products and the final rounding.
// Throughput is one transaction per cycle while the receiver does not stall.
// When the receiver stalls the whole pipeline holds; input ready falls only
// while the final stage holds an untaken result, so nothing is lost.
// Reset clears all valid bits; the payload registers are not reset.
// ----------------------------------------------------------------------------
module euler_to_quaternion_unit #(
    parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  e2q_pkg::t_angles i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output e2q_pkg::t_quat   o_data
);
    import e2q_pkg::*;

    // Valid shift chain, stages 1..6.
    logic [5:0] r_vld;
    logic       en;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    // Stages 1 to 3: trig of each half angle (raw field is the half angle).
    t_sc sc_y, sc_p, sc_r;
    e2q_trig u_trig_y (.i_clk, .i_en(en), .i_angle(i_data.yaw_angle),   .o_sc(sc_y));
    e2q_trig u_trig_p (.i_clk, .i_en(en), .i_angle(i_data.pitch_angle), .o_sc(sc_p));
    e2q_trig u_trig_r (.i_clk, .i_en(en), .i_angle(i_data.roll_angle),  .o_sc(sc_r));

    // Q4.60 to Q2.30, round to nearest with ties away from zero.
    function automatic logic signed [TRIG_W-1:0] rnd_q30(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + (v[63] ? (64'sd1 <<< 29) - 64'sd1 : (64'sd1 <<< 29));
        return TRIG_W'(t >>> 30);
    endfunction

    // Stage 4: pairwise products, Q2.30.
    logic signed [TRIG_W-1:0] r_crcp, r_srsp, r_srcp, r_crsp;
    t_sc r_y3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_crcp <= rnd_q30(64'(sc_r.c) * 64'(sc_p.c));
            r_srsp <= rnd_q30(64'(sc_r.s) * 64'(sc_p.s));
            r_srcp <= rnd_q30(64'(sc_r.s) * 64'(sc_p.c));
            r_crsp <= rnd_q30(64'(sc_r.c) * 64'(sc_p.s));
            r_y3   <= sc_y;
        end
    end

    // Stage 5: triple products and sums, Q4.60.
    logic signed [63:0] r_w, r_x, r_yq, r_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w  <= 64'(r_crcp) * 64'(r_y3.c) + 64'(r_srsp) * 64'(r_y3.s);
            r_x  <= 64'(r_srcp) * 64'(r_y3.c) - 64'(r_crsp) * 64'(r_y3.s);
            r_yq <= 64'(r_crsp) * 64'(r_y3.c) + 64'(r_srcp) * 64'(r_y3.s);
            r_z  <= 64'(r_crcp) * 64'(r_y3.s) - 64'(r_srsp) * 64'(r_y3.c);
        end
    end

    // Stage 6: round to nearest, ties away from zero.
    localparam int SH = 60 - OUT_FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (SH - 1);

    function automatic logic [QUAT_W-1:0] rnd(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + (v[63] ? HALF - 64'sd1 : HALF);
        return QUAT_W'(t >>> SH);
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_data.quat_w <= signed'(rnd(r_w));
            o_data.quat_x <= signed'(rnd(r_x));
            o_data.quat_y <= signed'(rnd(r_yq));
            o_data.quat_z <= signed'(rnd(r_z));
        end
    end
endmodule

// ===== rtl/core/e2q_checker.sv =====
// ----------------------------------------------------------------------------
// e2q_checker
// Port-level checks for the Euler angle to quaternion unit.
// ----------------------------------------------------------------------------
module e2q_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input e2q_pkg::t_quat   o_data
);
    import e2q_pkg::*;

    // Output holds while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output changed while stalled");

    // Ready follows the output side directly.
    a_rdy: assert property (@(posedge i_clk)
        !o_valid |-> o_ready)
        else $error("ready low with empty output");

    // No output right after reset.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // An accepted transaction reaches the output when no stall intervenes.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready ##1 o_ready ##1 o_ready ##1 o_ready ##1 o_ready
        ##1 o_ready |-> ##1 o_valid)
        else $error("transaction lost");
endmodule

bind euler_to_quaternion_unit e2q_checker u_e2q_checker (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready, .o_data
);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Euler angle to quaternion unit.
// ----------------------------------------------------------------------------
// Angle triples are sent over the input handshake. Each accepted transaction
// is run through a local fixed-point model of the half-angle trig and the
// yaw-pitch-roll product formulas. Each output transaction is compared, field
// by field, with the oldest prediction. A tolerance of two codes is allowed
// because the unit uses sine tables rather than a polynomial.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import e2q_pkg::*;

    // Widths and constants of the fixed-point quaternion model.
    localparam int         OUT_FRAC     = OUT_FRAC_BITS_DEF;
    localparam int         TOLERANCE    = 2;
    localparam int         TURN_UNITS   = 46080;
    localparam int         QUAD_UNITS   = 11520;
    localparam int         OCT_UNITS    = 5760;
    localparam longint     Q30_ONE      = 64'sd1 << 30;
    localparam longint     RAD_PER_UNIT = 149922641;  // pi/23040 in Q0.40
    localparam int         STALL_LIMIT  = 4000;
    localparam int         ANGLE_MAX    = 23040;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_angles  i_data;
    logic     o_valid;
    logic     i_ready = 1'b0;
    t_quat    o_data;

    // Predicted quaternions, oldest first.
    t_quat    quat_expected_q[$];
    int       fail_count = 0;
    int       quats_checked = 0;
    int       angles_sent = 0;
    int       quiet_cycles = 0;
    bit       tx_idling;
    bit       rx_idling;
    int       rx_stall_left = 0;

    euler_to_quaternion_unit #(
        .OUT_FRAC_BITS(OUT_FRAC)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Quaternion model
    // ------------------------------------------------------------------

    // Signed right shift with rounding to nearest, ties away from zero.
    function automatic longint round_away(input longint v, input int sh);
        longint unsigned mag;
        mag = (v < 0) ? longint'(-v) : v;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // Sine and cosine in Q2.30 of an angle within the first octant, given
    // in 1/128 degree units. Both series are evaluated Horner style.
    function automatic void octant_sin_cos(input int t, output longint s,
                                           output longint c);
        int unsigned     sin_div [6];
        int unsigned     cos_div [6];
        longint unsigned x;
        longint unsigned x2;
        longint unsigned p;
        sin_div = '{156, 110, 72, 42, 20, 6};
        cos_div = '{132, 90, 56, 30, 12, 2};
        x  = (longint'(t) * RAD_PER_UNIT + 512) >> 10;
        x2 = (x * x) >> 30;
        p  = Q30_ONE;
        for (int i = 0; i < 6; i++) begin
            p = Q30_ONE - ((x2 * p) >> 30) / sin_div[i];
        end
        s = longint'((x * p) >> 30);
        p = Q30_ONE;
        for (int i = 0; i < 6; i++) begin
            p = Q30_ONE - ((x2 * p) >> 30) / cos_div[i];
        end
        c = longint'(p);
    endfunction

    // The raw 1/64 degree field is also the half angle in 1/128 degree units.
    function automatic void half_angle_sin_cos(input logic signed [15:0] raw,
                                               output longint s,
                                               output longint c);
        int     a;
        int     quadrant;
        int     rem;
        longint s0;
        longint c0;
        a = int'(raw);
        if (a < 0) begin
            a += TURN_UNITS;
        end
        quadrant = a / QUAD_UNITS;
        rem      = a % QUAD_UNITS;
        if (rem <= OCT_UNITS) begin
            octant_sin_cos(rem, s0, c0);
        end else begin
            octant_sin_cos(QUAD_UNITS - rem, c0, s0);
        end
        case (quadrant % 4)
            0: begin s = s0;  c = c0;  end
            1: begin s = c0;  c = -s0; end
            2: begin s = -s0; c = -c0; end
            default: begin s = -c0; c = s0; end
        endcase
    endfunction

    function automatic logic [15:0] to_quat_code(input longint q60);
        return 16'(round_away(q60, 60 - OUT_FRAC));
    endfunction

    function automatic t_quat predict_quat(input t_angles a);
        longint sy, cy, sp, cp, sr, cr;
        longint crcp, srsp, srcp, crsp;
        t_quat  q;
        half_angle_sin_cos(a.yaw_angle, sy, cy);
        half_angle_sin_cos(a.pitch_angle, sp, cp);
        half_angle_sin_cos(a.roll_angle, sr, cr);
        crcp = round_away(cr * cp, 30);
        srsp = round_away(sr * sp, 30);
        srcp = round_away(sr * cp, 30);
        crsp = round_away(cr * sp, 30);
        q.quat_w = to_quat_code(crcp * cy + srsp * sy);
        q.quat_x = to_quat_code(srcp * cy - crsp * sy);
        q.quat_y = to_quat_code(crsp * cy + srcp * sy);
        q.quat_z = to_quat_code(crcp * sy - srsp * cy);
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Output side: random back-pressure and the result check.
    // ------------------------------------------------------------------

    function automatic void compare_component(input string name,
                                              input logic [15:0] expected,
                                              input logic [15:0] actual);
        shortint diff;
        diff = shortint'(actual - expected);
        if (diff > TOLERANCE || diff < -TOLERANCE) begin
            $error("%s mismatch: expected %0d, actual %0d", name,
                   $signed(expected), $signed(actual));
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_quat exp_q;
        if (i_rst_n && o_valid && i_ready) begin
            if (quat_expected_q.size() == 0) begin
                $error("unexpected output transaction %h", o_data);
                fail_count++;
            end else begin
                exp_q = quat_expected_q.pop_front();
                compare_component("quat_w", exp_q.quat_w, o_data.quat_w);
                compare_component("quat_x", exp_q.quat_x, o_data.quat_x);
                compare_component("quat_y", exp_q.quat_y, o_data.quat_y);
                compare_component("quat_z", exp_q.quat_z, o_data.quat_z);
                quats_checked++;
            end
        end
        // Random stall bursts are inserted while idling is enabled.
        if (!rx_idling) begin
            i_ready <= 1'b1;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            rx_stall_left = $urandom_range(0, 11);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog: too many cycles without any transaction ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d results pending",
                     quat_expected_q.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Sends one angle triple. Valid stays high from the previous transaction
    // unless an idle gap is taken, so it is never dropped and raised again
    // within one edge.
    task automatic send_angles(input t_angles a);
        int gap;
        gap = 0;
        if (tx_idling && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= a;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        quat_expected_q.push_back(predict_quat(a));
        angles_sent++;
    endtask

    task automatic send_triple(input int yaw, input int pitch, input int roll);
        t_angles a;
        a.yaw_angle   = 16'(yaw);
        a.pitch_angle = 16'(pitch);
        a.roll_angle  = 16'(roll);
        send_angles(a);
    endtask

    function automatic logic [15:0] random_angle();
        // Mostly the stated range, sometimes any 16-bit pattern.
        if ($urandom_range(0, 9) == 0) begin
            return 16'($urandom_range(0, 65535));
        end
        return 16'($signed($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
    endfunction

    // Waits until every predicted quaternion has arrived.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (quat_expected_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Zero, quadrant and octant boundaries, range limits and the extremes of
    // the raw 16-bit field, which wrap through the full-turn reduction.
    task automatic test_directed_angles();
        int corner [12];
        corner = '{0, 1, -1, 5760, 11520, 17280, 23040, -5760, -23040,
                   32767, -32768, 12345};
        for (int i = 0; i < 12; i++) begin
            send_triple(corner[i], corner[(i + 4) % 12], corner[(i + 8) % 12]);
        end
        send_triple(16'h5555, 16'hAAAA, 16'h0F0F);
        send_triple(16'hAAAA, 16'h5555, 16'hF0F0);
        send_triple(5761, 5759, 11519);
        send_triple(23040, 23040, 23040);
        send_triple(-23040, -23040, -23040);
    endtask

    task automatic test_random_angles(input int count);
        t_angles a;
        for (int i = 0; i < count; i++) begin
            a.yaw_angle   = random_angle();
            a.pitch_angle = random_angle();
            a.roll_angle  = random_angle();
            send_angles(a);
        end
    endtask

    // The sender holds off until the pipeline is empty, then resumes.
    task automatic test_pause_and_resume();
        test_random_angles(40);
        wait_for_drain();
        test_random_angles(40);
    endtask

    // Back to back traffic at full rate with no stalls on either side.
    task automatic test_full_rate();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        test_random_angles(150);
    endtask

    initial begin
        tx_idling     = 1'b1;
        rx_idling     = 1'b1;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_angles();
        test_random_angles(600);
        test_pause_and_resume();
        test_full_rate();

        wait_for_drain();
        // Let the pipeline settle before reporting.
        repeat (12) @(posedge i_clk);

        $display("Sent %0d angle triples (corners, wrapped raw codes, random)",
                 angles_sent);
        $display("Checked %0d quaternions under random stalls and full rate",
                 quats_checked);
        if (fail_count == 0 && quat_expected_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
